// ===== rtl/core/pxcv_pkg.sv =====
// ----------------------------------------------------------------------------
// pxcv_pkg
// Shared widths, register indexes and reset values of the proximity to
// control value block.
// ----------------------------------------------------------------------------
package pxcv_pkg;

    localparam int unsigned FRACTION_BITS_DEF = 8;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned CTRL_W     = 7;
    localparam int unsigned ALPHA_W    = 9;
    localparam int unsigned RANGE_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd4;

    // reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd51;
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST = 16'd512;
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST = 16'd30000;
    localparam logic [CTRL_W-1:0]  DEADZONE_RST  = 7'd2;

    // alpha of one in Q1.8, and the top of the control range
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;
    localparam logic [CTRL_W-1:0]  CTRL_MAX   = 7'd127;

endpackage

// ===== rtl/core/pxcv_filter.sv =====
// ----------------------------------------------------------------------------
// pxcv_filter
// First-order IIR smoother. Bit-serial multiply over the alpha bits, MSB
// first, then round half up and store the new level.
// ----------------------------------------------------------------------------
module pxcv_filter #(
    parameter int unsigned FRAC_BITS = pxcv_pkg::FRACTION_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [pxcv_pkg::SAMPLE_W-1:0]              i_sample,
    input  logic [pxcv_pkg::ALPHA_W-1:0]               i_alpha,
    output logic                                       o_done,
    output logic [pxcv_pkg::SAMPLE_W+FRAC_BITS-1:0]    o_level
);
    import pxcv_pkg::*;

    localparam int unsigned LW    = SAMPLE_W + FRAC_BITS;
    localparam int unsigned AW    = LW + 8;
    localparam int unsigned CNT_W = $clog2(ALPHA_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [ALPHA_W-1:0]   r_wa;
    logic [ALPHA_W-1:0]   r_wb;
    logic [LW-1:0]        r_xs;
    logic [LW-1:0]        r_level;
    logic [AW-1:0]        r_acc;

    logic [ALPHA_W-1:0]   w_a_sat;
    logic [ALPHA_W-1:0]   w_b;
    logic [AW-1:0]        w_term_x;
    logic [AW-1:0]        w_term_l;
    logic [AW-1:0]        w_sum;
    logic [AW-1:0]        w_round;

    // saturate alpha at one; the old level gets the rest of the weight
    assign w_a_sat = (i_alpha > ALPHA_FULL) ? ALPHA_FULL : i_alpha;
    assign w_b     = ALPHA_FULL - w_a_sat;

    assign w_term_x = r_wa[ALPHA_W-1] ? {{8{1'b0}}, r_xs}    : '0;
    assign w_term_l = r_wb[ALPHA_W-1] ? {{8{1'b0}}, r_level} : '0;
    assign w_sum    = {r_acc[AW-2:0], 1'b0} + w_term_x + w_term_l;
    assign w_round  = r_acc + {{(AW-8){1'b0}}, 8'd128};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_level <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(ALPHA_W);
                r_wa   <= w_a_sat;
                r_wb   <= w_b;
                r_xs   <= {i_sample, {FRAC_BITS{1'b0}}};
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    // shift in one weight bit of each product
                    r_acc  <= w_sum;
                    r_wa   <= {r_wa[ALPHA_W-2:0], 1'b0};
                    r_wb   <= {r_wb[ALPHA_W-2:0], 1'b0};
                    r_cnt  <= r_cnt - 1'b1;
                    r_done <= 1'b0;
                end else begin
                    r_level <= w_round[AW-1:8];
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done  = r_done;
    assign o_level = r_level;

endmodule

// ===== rtl/core/pxcv_scale.sv =====
// ----------------------------------------------------------------------------
// pxcv_scale
// Maps the smoothed level onto 0..127 with clamping, rounding half up.
// Restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pxcv_scale #(
    parameter int unsigned FRAC_BITS = pxcv_pkg::FRACTION_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [pxcv_pkg::SAMPLE_W+FRAC_BITS-1:0]  i_level,
    input  logic [pxcv_pkg::RANGE_W-1:0]             i_range_min,
    input  logic [pxcv_pkg::RANGE_W-1:0]             i_range_max,
    output logic                                     o_done,
    output logic [pxcv_pkg::CTRL_W-1:0]              o_value
);
    import pxcv_pkg::*;

    localparam int unsigned LW    = SAMPLE_W + FRAC_BITS;
    localparam int unsigned RW    = LW + 8;
    localparam int unsigned CNT_W = $clog2(CTRL_W + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_LOAD = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;
    localparam logic [1:0] P_DONE = 2'd3;

    logic [1:0]        r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic [LW-1:0]     r_d;
    logic [LW-1:0]     r_span;
    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_div;
    logic [CTRL_W-1:0] r_q;

    logic [LW-1:0]     w_lo;
    logic [LW-1:0]     w_hi;

    assign w_lo = {i_range_min, {FRAC_BITS{1'b0}}};
    assign w_hi = {i_range_max, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        // clamp at both ends before any division
                        if (i_level <= w_lo) begin
                            r_q     <= '0;
                            r_phase <= P_DONE;
                        end else if (i_level >= w_hi) begin
                            r_q     <= CTRL_MAX;
                            r_phase <= P_DONE;
                        end else begin
                            r_d     <= i_level - w_lo;
                            r_span  <= w_hi - w_lo;
                            r_phase <= P_LOAD;
                        end
                    end
                end
                P_LOAD: begin
                    // numerator 254*d + span, divisor 2*span aligned to the top bit
                    r_rem   <= ({r_d, 8'd0} - {{7{1'b0}}, r_d, 1'b0})
                               + {{8{1'b0}}, r_span};
                    r_div   <= {1'b0, r_span, 7'd0};
                    r_q     <= '0;
                    r_cnt   <= CNT_W'(CTRL_W);
                    r_phase <= P_DIV;
                end
                P_DIV: begin
                    if (r_rem >= r_div) begin
                        r_rem <= r_rem - r_div;
                        r_q   <= {r_q[CTRL_W-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[CTRL_W-2:0], 1'b0};
                    end
                    r_div <= {1'b0, r_div[RW-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_phase <= P_DONE;
                    end
                end
                P_DONE: begin
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_phase == P_DONE);
    assign o_value = r_q;

endmodule

// ===== rtl/core/proximity_to_control_value.sv =====
// ----------------------------------------------------------------------------
// proximity_to_control_value
// Smooths raw proximity samples, scales them onto a 7-bit control value and
// emits a value only when it moves by at least the deadzone.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ---------------------------
//  input     in         i_in_valid / o_in_stall   i_sample (16 b)
//  output    out        o_out_valid / i_out_stall o_control_value (7 b)
//  config    in         i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//
//  Sequence: a request passes the 9-step serial multiply-accumulate over the
//  alpha bits, then, when the level lies inside the range, the 7-step
//  restoring divider; a level that clamps skips the divider. One request is
//  in flight at a time.
//  Reset: synchronous, active low; restores the register defaults, clears the
//  smoothed level and the last emitted value.
//  Stalls: o_in_stall is high while a request is in flight. A finished result
//  sits in the output register while the next request is already taken; if a
//  second result to emit is ready before the first is taken, the block holds it.
//
module proximity_to_control_value #(
    parameter int unsigned FRACTION_BITS = pxcv_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input requests
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pxcv_pkg::SAMPLE_W-1:0]      i_sample,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pxcv_pkg::CTRL_W-1:0]        o_control_value,
    // configuration writes
    input  logic                               i_cfg_wr_en,
    input  logic [pxcv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pxcv_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import pxcv_pkg::*;

    localparam int unsigned LW = SAMPLE_W + FRACTION_BITS;

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FILT  = 2'd1;
    localparam logic [1:0] S_SCALE = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]         r_state;

    // configuration registers
    logic [ALPHA_W-1:0] r_alpha;
    logic [RANGE_W-1:0] r_range_min;
    logic [RANGE_W-1:0] r_range_max;
    logic [CTRL_W-1:0]  r_deadzone;
    logic               r_invert;

    // deadband state and output register
    logic [CTRL_W-1:0]  r_last;
    logic [CTRL_W-1:0]  r_value;
    logic               r_emit;
    logic               r_out_valid;
    logic [CTRL_W-1:0]  r_out_value;

    logic               w_accept;
    logic               w_filt_done;
    logic [LW-1:0]      w_level;
    logic               w_scale_done;
    logic [CTRL_W-1:0]  w_scaled;
    logic [CTRL_W-1:0]  w_v;
    logic [CTRL_W-1:0]  w_diff;
    logic               w_out_free;
    logic               w_load;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // smoother: holds the Q16.F level across requests
    pxcv_filter #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_sample (i_sample),
        .i_alpha  (r_alpha),
        .o_done   (w_filt_done),
        .o_level  (w_level)
    );

    // range mapper: launch as soon as the new level is stored
    pxcv_scale #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_filt_done),
        .i_level     (w_level),
        .i_range_min (r_range_min),
        .i_range_max (r_range_max),
        .o_done      (w_scale_done),
        .o_value     (w_scaled)
    );

    // polarity, then distance from the last emitted value
    assign w_v    = r_invert ? (CTRL_MAX - w_scaled) : w_scaled;
    assign w_diff = (w_v >= r_last) ? (w_v - r_last) : (r_last - w_v);

    // output register can take a value when empty or being drained now
    assign w_out_free = !r_out_valid || !i_out_stall;
    // a held result moves into the output register this cycle
    assign w_load     = (r_state == S_HOLD) && r_emit && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RST;
            r_range_min <= RANGE_MIN_RST;
            r_range_max <= RANGE_MAX_RST;
            r_deadzone  <= DEADZONE_RST;
            r_invert    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ALPHA:     r_alpha     <= i_cfg_wdata[ALPHA_W-1:0];
                REG_RANGE_MIN: r_range_min <= i_cfg_wdata[RANGE_W-1:0];
                REG_RANGE_MAX: r_range_max <= i_cfg_wdata[RANGE_W-1:0];
                REG_DEADZONE:  r_deadzone  <= i_cfg_wdata[CTRL_W-1:0];
                REG_INVERT:    r_invert    <= i_cfg_wdata[0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drain the output register when taken and nothing refills it
            if (r_out_valid && !i_out_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (w_filt_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    // capture the candidate and its deadband decision
                    if (w_scale_done) begin
                        r_value <= w_v;
                        r_emit  <= (w_diff >= r_deadzone);
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_emit) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_value;
                        r_last      <= r_value;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_control_value = r_out_value;

    // an accepted request always starts the smoother
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_FILT))
        else $error("accepted request did not enter filter phase");

    // filter completion only while the sequencer waits for it
    a_filt_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_filt_done |-> (r_state == S_FILT))
        else $error("filter done outside filter phase");

    // scaler completion only while the sequencer waits for it
    a_scale_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scale_done |-> (r_state == S_SCALE))
        else $error("scale done outside scale phase");

    // a loaded result always becomes the remembered value
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && r_emit && w_out_free)
            |=> (r_out_valid && r_out_value == r_last))
        else $error("emitted value not loaded or not remembered");

endmodule
